>>> rtl/core/sse_pkg.sv
// Sorted set engine package: command and status codes, result struct, sequencer states.
// No dependencies; every other file of the block imports it.
package sse_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_SEARCH = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DUP      = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic               empty_res;
      logic [COUNT_W-1:0] entry_count;
   } sse_result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MOVE,
      S_PUT,
      S_DONE
   } state_type;

endpackage

>>> rtl/core/sse_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on sse_pkg for field widths.
interface sse_req_if import sse_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                cmd;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sse_rsp_if import sse_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic               found;
   logic               empty_res;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, output status, output found, output empty_res,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input found, input empty_res,
                   input entry_count, output ready);
endinterface

>>> rtl/core/sse_mem.sv
// Value store: one write port, one read port, registered read data.
// Depends on sse_pkg for the value width.
module sse_mem import sse_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [AW-1:0]             waddr,
   input  logic signed [VALUE_W-1:0] wdata,
   input  logic [AW-1:0]             raddr,
   output logic signed [VALUE_W-1:0] rdata
);

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/sse_ctrl.sv
// Sequencer: scans the store for the lower bound, then shifts entries to
// insert or remove. Depends on sse_pkg; drives the ports of sse_mem.
module sse_ctrl import sse_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int AW       = 6,
   parameter int CW       = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [1:0]                req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      req_ready,
   output sse_result_type            res,
   output logic                      res_valid,
   input  logic                      slot_free,
   output logic                      mem_we,
   output logic [AW-1:0]             mem_waddr,
   output logic signed [VALUE_W-1:0] mem_wdata,
   output logic [AW-1:0]             mem_raddr,
   input  logic signed [VALUE_W-1:0] mem_rdata
);

   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   state_type                 state_ff, state_in;
   logic [1:0]                cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             scan_ff, scan_in;
   logic                      pend_ff, pend_in;
   logic [CW-1:0]             pos_ff, pos_in;
   logic                      found_ff, found_in;
   logic [CW-1:0]             left_ff, left_in;
   logic [AW-1:0]             rd_ff, rd_in;
   logic [AW-1:0]             wa_ff, wa_in;
   logic [1:0]                status_ff, status_in;

   logic hit;
   logic is_ins;

   assign hit    = pend_ff && (mem_rdata >= value_ff);
   assign is_ins = (cmd_ff == CMD_INSERT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      cmd_ff    <= cmd_in;
      value_ff  <= value_in;
      scan_ff   <= scan_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
      left_ff   <= left_in;
      rd_ff     <= rd_in;
      wa_ff     <= wa_in;
      status_ff <= status_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SCAN;
         S_SCAN:   if (hit || scan_ff == count_ff) state_in = S_DECIDE;
         S_DECIDE: begin
            if (is_ins && !found_ff && count_ff < CAP_C) begin
               state_in = S_MOVE;
            end else if (cmd_ff == CMD_REMOVE && found_ff) begin
               state_in = S_MOVE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MOVE:   if (left_ff == '0 && !pend_ff) state_in = is_ins ? S_PUT : S_DONE;
         S_PUT:    state_in = S_DONE;
         S_DONE:   if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      cmd_in    = cmd_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      left_in   = left_ff;
      rd_in     = rd_ff;
      wa_in     = wa_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: begin
            cmd_in   = req_cmd;
            value_in = req_value;
            scan_in  = '0;
            pend_in  = 1'b0;
         end
         S_SCAN: begin
            if (hit) begin
               pos_in   = scan_ff - ONE_C;
               found_in = (mem_rdata == value_ff);
               pend_in  = 1'b0;
            end else if (scan_ff == count_ff) begin
               pos_in   = count_ff;
               found_in = 1'b0;
               pend_in  = 1'b0;
            end else begin
               scan_in = scan_ff + ONE_C;
               pend_in = 1'b1;
            end
         end
         S_DECIDE: begin
            pend_in = 1'b0;
            if (is_ins) begin
               if (found_ff) begin
                  status_in = ST_DUP;
               end else if (count_ff >= CAP_C) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_OK;
                  left_in   = count_ff - pos_ff;
                  rd_in     = AW'(count_ff - ONE_C);
               end
            end else if (cmd_ff == CMD_REMOVE) begin
               if (found_ff) begin
                  status_in = ST_OK;
                  left_in   = count_ff - pos_ff - ONE_C;
                  rd_in     = AW'(pos_ff + ONE_C);
               end else begin
                  status_in = ST_NOTFOUND;
               end
            end else begin
               // search, and the unused code treated as search
               status_in = found_ff ? ST_OK : ST_NOTFOUND;
            end
         end
         S_MOVE: begin
            if (left_ff != '0) begin
               left_in = left_ff - ONE_C;
               pend_in = 1'b1;
               rd_in   = is_ins ? rd_ff - AW'(1) : rd_ff + AW'(1);
               wa_in   = is_ins ? rd_ff + AW'(1) : rd_ff - AW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff && !is_ins) count_in = count_ff - ONE_C;
            end
         end
         S_PUT:   count_in = count_ff + ONE_C;
         S_DONE:  ;
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = 1'b0;
      res_valid       = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = wa_ff;
      mem_wdata       = mem_rdata;
      mem_raddr       = rd_ff;
      res.status      = status_ff;
      res.found       = found_ff;
      res.empty_res   = (count_ff == '0);
      res.entry_count = COUNT_W'(count_ff);
      case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_SCAN:  mem_raddr = AW'(scan_ff);
         S_MOVE:  mem_we = pend_ff;
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pos_ff);
            mem_wdata = value_ff;
         end
         S_DONE:  res_valid = slot_free;
         default: ;
      endcase
   end

endmodule

>>> rtl/core/sorted_set_engine_top.sv
// Sorted set engine: set of distinct signed 32-bit values kept ascending in one memory.
// An insert scans for its place, shifts the later entries up and writes the value; a remove
// scans, then shifts the later entries down; a search or a rejected request only scans.
// One item at a time; the next request is taken in the cycle the response turns valid.
// Reset (synchronous, active high) empties the set; the memory itself is never cleared.
// Depends on sse_pkg, sse_if, sse_mem and sse_ctrl.
module sorted_set_engine_top import sse_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic      clock,
   input  logic      reset,
   sse_req_if.sink   req_if,
   sse_rsp_if.source rsp_if
);

   // address and count widths follow the capacity
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic signed [VALUE_W-1:0] mem_wdata;
   logic [AW-1:0]             mem_raddr;
   logic signed [VALUE_W-1:0] mem_rdata;

   sse_result_type res;
   logic           res_valid;
   logic           slot_free;

   // output register: holds one finished item so the sequencer can start the next
   sse_result_type rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   sse_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // scan for the first entry not below the value, then shift up (insert)
   // or down (remove) one entry per cycle, each written from the registered read data
   sse_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_value (req_if.value),
      .req_ready (req_if.ready),
      .res       (res),
      .res_valid (res_valid),
      .slot_free (slot_free),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // slot frees up in the same cycle the waiting item is taken
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_ff.status;
   assign rsp_if.found       = rsp_ff.found;
   assign rsp_if.empty_res   = rsp_ff.empty_res;
   assign rsp_if.entry_count = rsp_ff.entry_count;

`ifndef SYNTHESIS
   // a finished item never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> slot_free)
      else $error("result handed over while output slot busy");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.empty_res |-> rsp_if.entry_count == '0)
      else $error("empty flag with nonzero count");

   a_dup_found: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status == ST_DUP |-> rsp_if.found)
      else $error("duplicate without found");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status == ST_FULL
         |-> rsp_if.entry_count == COUNT_W'(CAPACITY) && !rsp_if.found)
      else $error("full status with wrong count");
`endif

endmodule

>>> tb/sorted_set_engine_top_tb.sv
// Self-checking bench for sorted_set_engine_top: a directed table, then random traffic.
// Each response is checked against a shadow sorted set updated on every accepted request,
// or against the typed-in response of a pinned row. Depends on sse_pkg and the sse_req_if / sse_rsp_if interfaces.
module sorted_set_engine_top_tb import sse_pkg::*; ();

   localparam int CAPACITY   = 64;
   localparam int RAND_ITEMS = 1750;
   // No handshake on either side for this long means the block is hung.
   localparam int HANG_LIMIT = 4000;
   // Watch past the drain for a span scaled with the capacity.
   localparam int TAIL_CYCLES = 2 * CAPACITY + 30;

   // Code 3 is unused by the block and must behave as a search.
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;

   // Traffic mixes for the random part.
   localparam int MIX_FILL  = 0;
   localparam int MIX_DRAIN = 1;
   localparam int MIX_BOTH  = 2;

   typedef struct {
      logic [1:0]                cmd;
      logic signed [VALUE_W-1:0] value;
      bit                        pinned;  // rsp typed in below, else predictor decides
      sse_result_type            rsp;
   } set_step_type;

   logic clock;
   logic reset;

   sse_req_if req_ch ();
   sse_rsp_if rsp_ch ();

   sorted_set_engine_top #(.CAPACITY(CAPACITY)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Shadow copy of the set: entries 0 .. set_size-1, ascending.
   logic signed [VALUE_W-1:0] set_vals [CAPACITY];
   int                        set_size;

   sse_result_type pending_rsp [$];

   // Item tags travel with valid, so the monitor sees the ones of the accepted item.
   bit             pin_now;
   sse_result_type pin_rsp;

   int send_idle_pct;
   int recv_idle_pct;
   int errors;
   int hang_cycles;
   int peak_size;
   int cmd_seen [4];
   int status_seen [4];

   // Directed rows. Pinned rows carry the response that follows from the commands above.
   localparam int PLAN_LEN = 25;
   set_step_type plan [PLAN_LEN] = '{
      // empty store right after reset
      '{CMD_SEARCH, 32'sd0,             1, '{ST_NOTFOUND, 1'b0, 1'b1, 7'd0}},
      '{CMD_REMOVE, 32'sd5,             1, '{ST_NOTFOUND, 1'b0, 1'b1, 7'd0}},
      // value extremes, duplicate insert
      '{CMD_INSERT, V_MIN,              1, '{ST_OK,       1'b0, 1'b0, 7'd1}},
      '{CMD_INSERT, V_MIN,              1, '{ST_DUP,      1'b1, 1'b0, 7'd1}},
      '{CMD_INSERT, V_MAX,              1, '{ST_OK,       1'b0, 1'b0, 7'd2}},
      '{CMD_INSERT, 32'sd0,             1, '{ST_OK,       1'b0, 1'b0, 7'd3}},
      '{CMD_INSERT, -32'sd1,            1, '{ST_OK,       1'b0, 1'b0, 7'd4}},
      '{CMD_SEARCH, V_MAX,              1, '{ST_OK,       1'b1, 1'b0, 7'd4}},
      '{CMD_SEARCH, 32'sd1,             1, '{ST_NOTFOUND, 1'b0, 1'b0, 7'd4}},
      // unused code acts as search
      '{CMD_SPARE,  32'sd0,             1, '{ST_OK,       1'b1, 1'b0, 7'd4}},
      '{CMD_SPARE,  32'sd7,             1, '{ST_NOTFOUND, 1'b0, 1'b0, 7'd4}},
      '{CMD_INSERT, V_MAX - 32'sd1,     0, '0},
      '{CMD_INSERT, V_MIN + 32'sd1,     0, '0},
      '{CMD_INSERT, 32'sd0,             1, '{ST_DUP,      1'b1, 1'b0, 7'd6}},
      // remove, remove of absent value, drain to empty
      '{CMD_REMOVE, 32'sd0,             1, '{ST_OK,       1'b1, 1'b0, 7'd5}},
      '{CMD_REMOVE, 32'sd0,             1, '{ST_NOTFOUND, 1'b0, 1'b0, 7'd5}},
      '{CMD_SEARCH, -32'sd1,            0, '0},
      '{CMD_REMOVE, V_MIN,              1, '{ST_OK,       1'b1, 1'b0, 7'd4}},
      '{CMD_REMOVE, V_MAX,              1, '{ST_OK,       1'b1, 1'b0, 7'd3}},
      '{CMD_REMOVE, -32'sd1,            1, '{ST_OK,       1'b1, 1'b0, 7'd2}},
      '{CMD_REMOVE, V_MAX - 32'sd1,     1, '{ST_OK,       1'b1, 1'b0, 7'd1}},
      '{CMD_REMOVE, V_MIN + 32'sd1,     1, '{ST_OK,       1'b1, 1'b1, 7'd0}},
      // alternating bit patterns
      '{CMD_INSERT, 32'sh5555_5555,     0, '0},
      '{CMD_INSERT, 32'shaaaa_aaaa,     0, '0},
      '{CMD_SEARCH, 32'sh5555_5555,     0, '0}
   };

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Shadow set update for one command; returns the response the block owes.
   function automatic sse_result_type apply_set_cmd(input logic [1:0] c,
                                                    input logic signed [VALUE_W-1:0] v);
      sse_result_type r;
      int             pos;
      bit             hit;
      pos = 0;
      while (pos < set_size && set_vals[pos] < v) pos++;
      hit = (pos < set_size) && (set_vals[pos] == v);
      r.found = hit;
      if (c == CMD_INSERT) begin
         if (hit) begin
            r.status = ST_DUP;        // duplicate wins over full
         end else if (set_size >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            for (int i = set_size; i > pos; i--) set_vals[i] = set_vals[i-1];
            set_vals[pos] = v;
            set_size++;
            r.status = ST_OK;
         end
      end else if (c == CMD_REMOVE) begin
         if (hit) begin
            for (int i = pos; i + 1 < set_size; i++) set_vals[i] = set_vals[i+1];
            set_size--;
            r.status = ST_OK;
         end else begin
            r.status = ST_NOTFOUND;
         end
      end else begin
         r.status = hit ? ST_OK : ST_NOTFOUND;
      end
      r.empty_res   = (set_size == 0);
      r.entry_count = COUNT_W'(set_size);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %0d at %0t: %s got %0d want %0d", errors, $realtime, what, got, want);
   endtask

   task automatic check_response();
      sse_result_type want;
      if (pending_rsp.size() == 0) begin
         report_mismatch("response with no request outstanding", 1, 0);
      end else begin
         want = pending_rsp.pop_front();
         if (rsp_ch.status !== want.status)
            report_mismatch("status", rsp_ch.status, want.status);
         if (rsp_ch.found !== want.found)
            report_mismatch("found", rsp_ch.found, want.found);
         if (rsp_ch.empty_res !== want.empty_res)
            report_mismatch("empty_res", rsp_ch.empty_res, want.empty_res);
         if (rsp_ch.entry_count !== want.entry_count)
            report_mismatch("entry_count", rsp_ch.entry_count, want.entry_count);
      end
   endtask

   // Request side monitor and response checker. Requests are logged first, so a
   // response in the same cycle still pops the older expectation.
   always @(posedge clock) begin
      sse_result_type pred;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            pred = apply_set_cmd(req_ch.cmd, req_ch.value);
            cmd_seen[req_ch.cmd]++;
            status_seen[pred.status]++;
            if (set_size > peak_size) peak_size = set_size;
            pending_rsp.push_back(pin_now ? pin_rsp : pred);
         end
         if (rsp_ch.valid && rsp_ch.ready) check_response();
      end
   end

   // Response backpressure: one draw per cycle.
   always @(posedge clock) begin
      rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // Hang detector: counts cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         hang_cycles = 0;
      else
         hang_cycles++;
      if (hang_cycles >= HANG_LIMIT) begin
         $display("no handshake for %0d cycles, %0d responses outstanding",
                  hang_cycles, pending_rsp.size());
         $display("status: fail");
         $finish;
      end
   end

   // Presents one item and returns at the edge where it is taken. Valid stays up
   // for back-to-back items; it drops only during a sender gap.
   task automatic send_item(input logic [1:0] c, input logic signed [VALUE_W-1:0] v,
                            input bit pinned, input sse_result_type rsp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= c;
      req_ch.value <= v;
      pin_now      <= pinned;
      pin_rsp      <= rsp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Mostly a dense small range so hits, duplicates and a full store are common;
   // the rest is full-range noise and the two's complement corners.
   function automatic logic signed [VALUE_W-1:0] draw_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return $signed(32'($urandom_range(95))) - 32'sd48;
      if (roll < 85) return $signed(32'($urandom));
      case ($urandom_range(5))
         0: return V_MIN;
         1: return V_MAX;
         2: return V_MIN + 32'sd1;
         3: return V_MAX - 32'sd1;
         4: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   initial begin
      logic signed [VALUE_W-1:0] inserted [$];
      logic signed [VALUE_W-1:0] v;
      logic [1:0]                c;
      int                        mix;
      int                        run_len;
      int                        roll;
      int                        ins_pct;
      int                        rem_pct;
      int                        sent;

      // Every input known from time zero.
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.cmd    = CMD_SEARCH;
      req_ch.value  = '0;
      rsp_ch.ready  = 1'b0;
      pin_now       = 1'b0;
      pin_rsp       = '0;
      set_size      = 0;
      errors        = 0;
      hang_cycles   = 0;
      peak_size     = 0;
      send_idle_pct = 29;
      recv_idle_pct = 86;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the first idling pattern.
      foreach (plan[i]) send_item(plan[i].cmd, plan[i].value, plan[i].pinned, plan[i].rsp);

      // Random part in three idling phases: slow receiver, slow sender, no gaps.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 29; recv_idle_pct = 86; end
            1: begin send_idle_pct = 86; recv_idle_pct = 29; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         sent = 0;
         while (sent < RAND_ITEMS / 3) begin
            // Runs of one traffic mix: fill runs drive the set to full,
            // drain runs empty it again.
            mix     = $urandom_range(2);
            run_len = $urandom_range(20, 120);
            case (mix)
               MIX_FILL:  begin ins_pct = 75; rem_pct = 10; end
               MIX_DRAIN: begin ins_pct = 15; rem_pct = 65; end
               default:   begin ins_pct = 40; rem_pct = 30; end
            endcase
            for (int k = 0; k < run_len && sent < RAND_ITEMS / 3; k++) begin
               roll = $urandom_range(99);
               if (roll < ins_pct)                c = CMD_INSERT;
               else if (roll < ins_pct + rem_pct) c = CMD_REMOVE;
               else if (roll < 97)                c = CMD_SEARCH;
               else                               c = CMD_SPARE;
               // Removes and searches often aim at a value sent for insert earlier.
               if (c != CMD_INSERT && inserted.size() > 0 && $urandom_range(99) < 50)
                  v = inserted[$urandom_range(inserted.size() - 1)];
               else
                  v = draw_value();
               send_item(c, v, 1'b0, '0);
               if (c == CMD_INSERT) begin
                  inserted.push_back(v);
                  if (inserted.size() > 2 * CAPACITY) void'(inserted.pop_front());
               end
               sent++;
            end
         end
      end
      req_ch.valid <= 1'b0;

      // Drain, then watch a little longer for stray responses.
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch("responses never returned", pending_rsp.size(), 0);

      $display("covered %0d inserts, %0d removes, %0d searches, %0d spare; peak fill %0d of %0d",
               cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE], cmd_seen[CMD_SEARCH],
               cmd_seen[CMD_SPARE], peak_size, CAPACITY);
      $display("outcomes: %0d ok, %0d duplicate, %0d not found, %0d store full; %0d mismatches",
               status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_NOTFOUND],
               status_seen[ST_FULL], errors);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
